// ===== design/ipv4dq_pkg.sv =====
package ipv4dq_pkg;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_SEEK   = 2'd2,
        PH_TAIL   = 2'd3
    } phase_t;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [8:0] OCTET_MAX  = 9'd255;
    localparam logic [8:0] OCTET_SAT  = 9'd256;
    localparam logic [1:0] LAST_OCTET = 2'd3;

endpackage

// ===== design/ipv4_dotted_quad_parser_unit.sv =====
// Parses a NUL-terminated dotted-decimal IPv4 string, one character per
// input word, into a 32-bit address (first octet in bits 31..24) and a
// status bit (1 = malformed or an octet above 255). Only the NUL word
// produces an output word; all other characters only advance the parse.
// One character is taken every clock unless the input is stalled: the
// whole per-character update of the parse state is one pass of logic
// between the input register and the state/output registers; throughput is
// one word per cycle, and a NUL's result is held in the output registers.
// Backpressure on the output stalls the input only while a finished result
// is still waiting and another NUL reaches the input register.
module ipv4_dotted_quad_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] address
    output logic        m_tuser     // [0] status
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  ch_reg, ch_next;

    ipv4dq_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  octet_index_reg, octet_index_next;
    logic [8:0]  octet_value_reg, octet_value_next;
    logic [31:0] addr_acc_reg, addr_acc_next;
    logic        failed_reg, failed_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic        out_status_reg, out_status_next;

    logic        is_nul, is_dot, is_digit, advance, ok;
    logic [11:0] acc_mul;
    logic [31:0] commit_val, committed;

    assign is_nul   = (ch_reg == ipv4dq_pkg::CHAR_NUL);
    assign is_dot   = (ch_reg == ipv4dq_pkg::CHAR_DOT);
    assign is_digit = (ch_reg >= ipv4dq_pkg::CHAR_ZERO) && (ch_reg <= ipv4dq_pkg::CHAR_NINE);

    // a non-NUL word never needs output space
    assign advance  = in_valid_reg && (!is_nul || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    // '0'..'9' are 0x30..0x39, so the low nibble is the digit value
    assign acc_mul = {3'b000, octet_value_reg} * 12'd10 + {8'b0, ch_reg[3:0]};

    always_comb begin
        case (octet_index_reg)
            2'd0:    commit_val = {octet_value_reg[7:0], 24'b0};
            2'd1:    commit_val = {8'b0, octet_value_reg[7:0], 16'b0};
            2'd2:    commit_val = {16'b0, octet_value_reg[7:0], 8'b0};
            default: commit_val = {24'b0, octet_value_reg[7:0]};
        endcase
    end

    assign committed = addr_acc_reg | commit_val;

    always_comb begin
        in_valid_next    = in_valid_reg;
        ch_next          = ch_reg;
        phase_next       = phase_reg;
        octet_index_next = octet_index_reg;
        octet_value_next = octet_value_reg;
        addr_acc_next    = addr_acc_reg;
        failed_next      = failed_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        ok               = 1'b0;

        if (s_tready) begin
            in_valid_next = s_tvalid;
            ch_next       = s_tdata;
        end

        if (advance) begin
            if (is_nul) begin
                ok = !failed_reg &&
                     ((phase_reg == ipv4dq_pkg::PH_DIGITS &&
                       octet_index_reg == ipv4dq_pkg::LAST_OCTET) ||
                      phase_reg == ipv4dq_pkg::PH_TAIL);
                out_valid_next   = 1'b1;
                out_status_next  = !ok;
                out_addr_next    = !ok ? 32'b0 :
                                   (phase_reg == ipv4dq_pkg::PH_DIGITS) ? committed :
                                   addr_acc_reg;
                phase_next       = ipv4dq_pkg::PH_SKIP;
                octet_index_next = 2'd0;
                octet_value_next = 9'd0;
                addr_acc_next    = 32'b0;
                failed_next      = 1'b0;
            end else if (!failed_reg) begin
                case (phase_reg)
                    ipv4dq_pkg::PH_SKIP: begin
                        if (is_digit) begin
                            octet_value_next = {5'b0, ch_reg[3:0]};
                            phase_next       = ipv4dq_pkg::PH_DIGITS;
                        end
                    end
                    ipv4dq_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            if (acc_mul > {3'b000, ipv4dq_pkg::OCTET_MAX}) begin
                                octet_value_next = ipv4dq_pkg::OCTET_SAT;
                                failed_next      = 1'b1;
                            end else begin
                                octet_value_next = acc_mul[8:0];
                            end
                        end else begin
                            addr_acc_next = committed;
                            if (octet_index_reg == ipv4dq_pkg::LAST_OCTET) begin
                                if (is_dot) begin
                                    failed_next = 1'b1;
                                end else begin
                                    phase_next = ipv4dq_pkg::PH_TAIL;
                                end
                            end else if (is_dot) begin
                                octet_index_next = octet_index_reg + 2'd1;
                                octet_value_next = 9'd0;
                                phase_next       = ipv4dq_pkg::PH_SKIP;
                            end else begin
                                phase_next = ipv4dq_pkg::PH_SEEK;
                            end
                        end
                    end
                    ipv4dq_pkg::PH_SEEK: begin
                        if (is_dot) begin
                            octet_index_next = octet_index_reg + 2'd1;
                            octet_value_next = 9'd0;
                            phase_next       = ipv4dq_pkg::PH_SKIP;
                        end
                    end
                    default: begin
                        if (is_dot) begin
                            failed_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= ipv4dq_pkg::PH_SKIP;
            octet_index_reg <= 2'd0;
            octet_value_reg <= 9'd0;
            addr_acc_reg    <= 32'b0;
            failed_reg      <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            octet_index_reg <= octet_index_next;
            octet_value_reg <= octet_value_next;
            addr_acc_reg    <= addr_acc_next;
            failed_reg      <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg         <= ch_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule
